// ----- design/bbd_pkg.sv -----
// shared types, constants and pixel math for the bilinear bayer demosaic block
// no dependencies; every other design file refers to it by scoped names
package bbd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int HGT_W     = 13;
    localparam int ROW_W     = $clog2(MAX_HEIGHT) + 1;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(580);
    localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(440);
    localparam logic [WID_W-1:0] WIDTH_MIN    = WID_W'(2);
    localparam logic [WID_W-1:0] WIDTH_MAX    = WID_W'(MAX_WIDTH);
    localparam logic [HGT_W-1:0] HEIGHT_MIN   = HGT_W'(2);
    localparam logic [HGT_W-1:0] HEIGHT_MAX   = HGT_W'(MAX_HEIGHT);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_FLUSH  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t          opcode;
        logic [PIX_W-1:0] raw_sample;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_end;
        logic             run_last;
    } out_item_t;

    // what the second stage needs to know about one transaction
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             col_zero;
        logic             row_le1;
        logic             drain;
        logic [PIX_W-1:0] raw;
        logic             emit_a;
        logic             emit_b;
        logic             prow_odd;
    } s1_ctl_t;

    // 3x3 window, index row*3 + column, column 2 is the newest
    typedef logic [8:0][PIX_W-1:0] window_t;

    function automatic window_t win_shift(window_t w, logic [PIX_W-1:0] top,
                                          logic [PIX_W-1:0] mid, logic [PIX_W-1:0] bot);
        window_t n;
        n    = w;
        n[0] = w[1];
        n[1] = w[2];
        n[3] = w[4];
        n[4] = w[5];
        n[6] = w[7];
        n[7] = w[8];
        n[2] = top;
        n[5] = mid;
        n[8] = bot;
        return n;
    endfunction

    function automatic window_t win_fill(logic [PIX_W-1:0] top, logic [PIX_W-1:0] mid,
                                         logic [PIX_W-1:0] bot);
        window_t n;
        n[0] = top;
        n[1] = top;
        n[2] = top;
        n[3] = mid;
        n[4] = mid;
        n[5] = mid;
        n[6] = bot;
        n[7] = bot;
        n[8] = bot;
        return n;
    endfunction

    function automatic out_item_t interp(window_t w, logic prow_odd, logic pcol_odd,
                                         logic fend, logic last);
        logic [PIX_W:0]   hz_s;
        logic [PIX_W:0]   vt_s;
        logic [PIX_W+1:0] cr_s;
        logic [PIX_W+1:0] dg_s;
        logic [PIX_W-1:0] hz;
        logic [PIX_W-1:0] vt;
        logic [PIX_W-1:0] cr;
        logic [PIX_W-1:0] dg;
        out_item_t        o;
        hz_s = {1'b0, w[3]} + {1'b0, w[5]} + (PIX_W+1)'(1);
        vt_s = {1'b0, w[1]} + {1'b0, w[7]} + (PIX_W+1)'(1);
        cr_s = {2'b0, w[1]} + {2'b0, w[3]} + {2'b0, w[5]} + {2'b0, w[7]} + (PIX_W+2)'(2);
        dg_s = {2'b0, w[0]} + {2'b0, w[2]} + {2'b0, w[6]} + {2'b0, w[8]} + (PIX_W+2)'(2);
        hz   = hz_s[PIX_W:1];
        vt   = vt_s[PIX_W:1];
        cr   = cr_s[PIX_W+1:2];
        dg   = dg_s[PIX_W+1:2];
        case ({prow_odd, pcol_odd})
            2'b00:
            begin
                o.red = hz;  o.green = w[4]; o.blue = vt;
            end
            2'b01:
            begin
                o.red = w[4]; o.green = cr; o.blue = dg;
            end
            2'b10:
            begin
                o.red = dg;  o.green = cr;   o.blue = w[4];
            end
            default:
            begin
                o.red = vt;  o.green = w[4]; o.blue = hz;
            end
        endcase
        o.frame_end = fend;
        o.run_last  = last;
        return o;
    endfunction

endpackage

// ----- design/bbd_line_mem.sv -----
// one row of the line store: synchronous ram, one write and one read port
// depends on bbd_pkg for depth and sample width
module bbd_line_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [bbd_pkg::COL_W-1:0]   waddr,
    input  logic [bbd_pkg::PIX_W-1:0]   wdata,
    input  logic                        re,
    input  logic [bbd_pkg::COL_W-1:0]   raddr,
    output logic [bbd_pkg::PIX_W-1:0]   rdata
);

    logic [bbd_pkg::PIX_W-1:0] mem_reg [bbd_pkg::MAX_WIDTH];
    logic [bbd_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/bbd_ctrl.sv -----
// config registers, raster counters and the read-issue stage
// depends on bbd_pkg
module bbd_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  bbd_pkg::in_item_t              in_data,
    output logic                           in_stall,
    input  logic                           cfg_we,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbd_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s1_fire,
    output logic                           rd_en,
    output logic [bbd_pkg::COL_W-1:0]      rd_addr,
    output logic                           s1_valid,
    output bbd_pkg::s1_ctl_t               s1_ctl
);

    logic [bbd_pkg::WID_W-1:0] width_reg, width_next;
    logic [bbd_pkg::HGT_W-1:0] height_reg, height_next;
    logic [bbd_pkg::COL_W-1:0] col_reg, col_next;
    logic [bbd_pkg::ROW_W-1:0] row_reg, row_next;
    logic                      s1_valid_reg, s1_valid_next;
    bbd_pkg::s1_ctl_t          s1_ctl_reg, s1_ctl_next;

    logic [bbd_pkg::WID_W-1:0] w_eff;
    logic [bbd_pkg::HGT_W-1:0] h_eff;
    logic                      accept;
    logic                      drain;
    logic                      active;
    logic                      row_end;
    logic                      row_nz;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (bbd_pkg::cfg_reg_t'(cfg_index))
                bbd_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_wdata[bbd_pkg::WID_W-1:0];
                bbd_pkg::REG_IMAGE_HEIGHT: height_next = cfg_wdata[bbd_pkg::HGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < bbd_pkg::WIDTH_MIN)
            w_eff = bbd_pkg::WIDTH_MIN;
        else if (width_reg > bbd_pkg::WIDTH_MAX)
            w_eff = bbd_pkg::WIDTH_MAX;
        else
            w_eff = width_reg;
        if (height_reg < bbd_pkg::HEIGHT_MIN)
            h_eff = bbd_pkg::HEIGHT_MIN;
        else if (height_reg > bbd_pkg::HEIGHT_MAX)
            h_eff = bbd_pkg::HEIGHT_MAX;
        else
            h_eff = height_reg;
    end

    assign in_stall = s1_valid_reg && !s1_fire;
    assign accept   = in_valid && !in_stall;
    assign drain    = bbd_pkg::HGT_W'(row_reg) >= h_eff;
    // a flush before the drain is taken and dropped
    assign active   = accept && (drain || (in_data.opcode != bbd_pkg::OP_FLUSH));
    assign row_end  = {1'b0, col_reg} >= (w_eff - bbd_pkg::WID_W'(1));
    assign row_nz   = (row_reg != '0);

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        s1_ctl_next = s1_ctl_reg;
        if (active)
        begin
            s1_ctl_next.col      = col_reg;
            s1_ctl_next.col_zero = (col_reg == '0);
            s1_ctl_next.row_le1  = (row_reg <= bbd_pkg::ROW_W'(1));
            s1_ctl_next.drain    = drain;
            s1_ctl_next.raw      = in_data.raw_sample;
            s1_ctl_next.emit_a   = row_nz && (col_reg != '0);
            s1_ctl_next.emit_b   = row_nz && row_end;
            // output row is one behind
            s1_ctl_next.prow_odd = ~row_reg[0];
            if (row_end)
            begin
                col_next = '0;
                row_next = drain ? '0 : row_reg + bbd_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + bbd_pkg::COL_W'(1);
            end
        end
        if (active)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= bbd_pkg::WIDTH_RESET;
            height_reg   <= bbd_pkg::HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctl_reg <= s1_ctl_next;
    end

    assign rd_en    = active;
    assign rd_addr  = col_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;

endmodule

// ----- design/bbd_window.sv -----
// second stage: line store write-back, 3x3 window and interpolation
// depends on bbd_pkg
module bbd_window (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s1_fire,
    input  bbd_pkg::s1_ctl_t             s1_ctl,
    input  logic [bbd_pkg::PIX_W-1:0]    top_rdata,
    input  logic [bbd_pkg::PIX_W-1:0]    mid_rdata,
    output logic                         wr_en,
    output logic [bbd_pkg::COL_W-1:0]    wr_addr,
    output logic [bbd_pkg::PIX_W-1:0]    top_wdata,
    output logic [bbd_pkg::PIX_W-1:0]    mid_wdata,
    output logic [1:0]                   push_n,
    output bbd_pkg::out_item_t           push_d0,
    output bbd_pkg::out_item_t           push_d1
);

    bbd_pkg::window_t          win_reg, win_next;
    bbd_pkg::window_t          win1;
    bbd_pkg::window_t          win2;
    logic [bbd_pkg::PIX_W-1:0] top;
    logic [bbd_pkg::PIX_W-1:0] mid;
    logic [bbd_pkg::PIX_W-1:0] bot;
    bbd_pkg::out_item_t        res_a;
    bbd_pkg::out_item_t        res_b;

    always_comb
    begin
        mid = mid_rdata;
        // first two rows replicate the top edge
        top = s1_ctl.row_le1 ? mid_rdata : top_rdata;
        // drain replicates the bottom edge
        bot = s1_ctl.drain ? mid_rdata : s1_ctl.raw;

        win1 = s1_ctl.col_zero ? bbd_pkg::win_fill(top, mid, bot)
                               : bbd_pkg::win_shift(win_reg, top, mid, bot);
        // last column sees itself again on the right
        win2 = bbd_pkg::win_shift(win1, top, mid, bot);

        res_a = bbd_pkg::interp(win1, s1_ctl.prow_odd, ~s1_ctl.col[0], 1'b0,
                                !s1_ctl.emit_b);
        res_b = bbd_pkg::interp(win2, s1_ctl.prow_odd, s1_ctl.col[0], s1_ctl.drain, 1'b1);

        win_next = win_reg;
        if (s1_fire)
            win_next = s1_ctl.emit_b ? win2 : win1;

        push_n  = 2'b00;
        push_d0 = res_a;
        push_d1 = res_b;
        if (s1_fire)
        begin
            if (s1_ctl.emit_a)
                push_n = s1_ctl.emit_b ? 2'd2 : 2'd1;
            else if (s1_ctl.emit_b)
            begin
                push_n  = 2'd1;
                push_d0 = res_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else
            win_reg <= win_next;
    end

    assign wr_en     = s1_fire;
    assign wr_addr   = s1_ctl.col;
    assign top_wdata = mid;
    assign mid_wdata = bot;

endmodule

// ----- design/bbd_res_fifo.sv -----
// small result queue: takes up to two pixels per cycle, gives one while out_stall is low
// depends on bbd_pkg
module bbd_res_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_n,
    input  bbd_pkg::out_item_t  push_d0,
    input  bbd_pkg::out_item_t  push_d1,
    output logic                room,
    output logic                out_valid,
    input  logic                out_stall,
    output bbd_pkg::out_item_t  out_data
);

    bbd_pkg::out_item_t              fifo_reg [bbd_pkg::FIFO_DEPTH];
    logic [bbd_pkg::FIFO_PTR_W-1:0]  wp_reg, wp_next;
    logic [bbd_pkg::FIFO_PTR_W-1:0]  rp_reg, rp_next;
    logic [bbd_pkg::FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [bbd_pkg::FIFO_PTR_W-1:0]  wp_inc;
    logic                            pop;

    assign pop    = (cnt_reg != '0) && !out_stall;
    assign wp_inc = wp_reg + bbd_pkg::FIFO_PTR_W'(1);

    always_comb
    begin
        rp_next  = pop ? rp_reg + bbd_pkg::FIFO_PTR_W'(1) : rp_reg;
        wp_next  = wp_reg + bbd_pkg::FIFO_PTR_W'(push_n);
        cnt_next = cnt_reg + bbd_pkg::FIFO_CNT_W'(push_n)
                 - bbd_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_reg[wp_reg] <= push_d0;
        if (push_n == 2'd2)
            fifo_reg[wp_inc] <= push_d1;
    end

    // room for a full pair regardless of this cycle's pop
    assign room      = cnt_reg <= bbd_pkg::FIFO_CNT_W'(bbd_pkg::FIFO_DEPTH - 2);
    assign out_valid = (cnt_reg != '0);
    assign out_data  = fifo_reg[rp_reg];

endmodule

// ----- design/bayer_bilinear_demosaic.sv -----
// Bilinear demosaic of a GRBG bayer raster stream, one RGB pixel per raw site.
// Takes one input transaction per clock unless stalled. Each transaction reads
// both line-store rows at its column in the cycle it is accepted and writes them
// back on leaving s1, so a column is revisited only a full row later and needs no
// forwarding. Pixels come out one row plus one column behind the raw stream; the
// last column of each output row yields two pixels and the first column of the
// next row yields none, so with the output side never stalling a four-entry result
// queue never holds more than two pixels and the input never stalls. After
// the last row, image_width flush transactions drain the final row; its last
// pixel carries frame_end. The line store needs no clearing after reset.
// depends on bbd_pkg, bbd_ctrl, bbd_line_mem, bbd_window and bbd_res_fifo
module bayer_bilinear_demosaic (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  bbd_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output bbd_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbd_pkg::CFG_W-1:0]      cfg_wdata
);

    logic                      s1_valid;
    logic                      s1_fire;
    bbd_pkg::s1_ctl_t          s1_ctl;
    logic                      rd_en;
    logic [bbd_pkg::COL_W-1:0] rd_addr;
    logic                      wr_en;
    logic [bbd_pkg::COL_W-1:0] wr_addr;
    logic [bbd_pkg::PIX_W-1:0] top_wdata;
    logic [bbd_pkg::PIX_W-1:0] mid_wdata;
    logic [bbd_pkg::PIX_W-1:0] top_rdata;
    logic [bbd_pkg::PIX_W-1:0] mid_rdata;
    logic [1:0]                push_n;
    bbd_pkg::out_item_t        push_d0;
    bbd_pkg::out_item_t        push_d1;
    logic                      room;

    assign s1_fire = s1_valid && room;

    bbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .in_stall  (in_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s1_fire   (s1_fire),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl)
    );

    // row two above the newest sample
    bbd_line_mem u_top_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (top_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (top_rdata)
    );

    // row just above the newest sample
    bbd_line_mem u_mid_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (mid_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (mid_rdata)
    );

    bbd_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_fire   (s1_fire),
        .s1_ctl    (s1_ctl),
        .top_rdata (top_rdata),
        .mid_rdata (mid_rdata),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .top_wdata (top_wdata),
        .mid_wdata (mid_wdata),
        .push_n    (push_n),
        .push_d0   (push_d0),
        .push_d1   (push_d1)
    );

    bbd_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_d0   (push_d0),
        .push_d1   (push_d1),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- design/bbd_checker.sv -----
// port-level checks for the bilinear demosaic top level, bound to it below
// depends on bbd_pkg and bayer_bilinear_demosaic
module bbd_port_checks (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_stall,
    input  bbd_pkg::out_item_t  out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("output payload changed while stalled");

    // end of frame is always the last pixel of its transaction
    a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_end |-> out_data.run_last)
        else $error("frame_end without run_last");

    // both pixels of a row end are queued together, so the second follows at once
    a_pair_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.run_last |=> out_valid && out_data.run_last)
        else $error("second pixel of a pair not ready");

endmodule

bind bayer_bilinear_demosaic bbd_port_checks u_bbd_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
